### rtl/ptb_pkg.sv
package ptb_pkg;

  localparam int USER_W = 8;
  localparam int USERS  = 1 << USER_W;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b0;
  localparam logic [ADDR_W-3:0] REG_RATE     = 1'b1;

  localparam logic [15:0] CAPACITY_RST = 16'd5;
  localparam logic [15:0] RATE_RST     = 16'd256;

  // 256000 = 2^11 * 125; divide by 125 through a scaled reciprocal
  localparam int REFILL_SHIFT = 11;
  localparam int QUOT_X_W     = 23;
  localparam int RECIP_SHIFT  = 30;
  localparam logic [23:0] RECIP_M   = 24'd8589935;
  localparam logic [36:0] SAT_LIMIT = 37'd8192000;

  typedef struct packed {
    logic [7:0]  user_id;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        allowed;
    logic [15:0] tokens_left;
  } rsp_t;

  typedef struct packed {
    logic [15:0] tokens;
    logic [31:0] stamp;
  } entry_t;

endpackage

### rtl/per_user_token_bucket.sv
// Channel  Handshake               Beat
// req      req_valid / req_stall   user_id, now_ms
// rsp      rsp_valid / rsp_stall   allowed, tokens_left
// cfg      APB write/read          capacity @0x0, rate_q8 @0x4
//
// A request walks through table read, rate multiply, reciprocal multiply,
// then refill, write-back and result load. The serial walk through the
// single bucket table and the two multipliers sets that order.
// A new request is taken while a finished result still waits in rsp.
// Synchronous reset clears all bucket valid marks at once; no clearing pass.
// A stalled rsp holds the last stage until the result register frees up.
module per_user_token_bucket (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  ptb_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output ptb_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptb_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ptb_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_MUL   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [15:0]       capacity;
  logic [15:0]       rate_q8;
  logic [USERS-1:0]  bucket_valid;
  logic [USER_W-1:0] slot;
  logic [31:0]       now;
  logic              hit;

  logic              accept;
  logic              finish;
  logic              cfg_write;
  logic [ADDR_W-3:0] reg_index;
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic [31:0]       elapsed;
  logic [15:0]       tokens_base;
  logic              allowed;
  logic [15:0]       tokens_left;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
      rate_q8  <= RATE_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_CAPACITY: capacity <= pwdata[15:0];
        REG_RATE:     rate_q8  <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_CAPACITY: prdata = {16'd0, capacity};
      REG_RATE:     prdata = {16'd0, rate_q8};
      default:      prdata = 32'd0;
    endcase
  end

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign finish    = (state == S_FIN) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_READ;
      S_READ:  state_next = S_MUL;
      S_MUL:   state_next = S_FIN;
      S_FIN:   if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot <= req.user_id[USER_W-1:0];
      now  <= req.now_ms;
      hit  <= bucket_valid[req.user_id[USER_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_valid <= '0;
    end else if (finish) begin
      bucket_valid[slot] <= 1'b1;
    end
  end

  assign wr_entry = '{tokens: tokens_left, stamp: now};

  ptb_bucket_ram u_ram (
    .clk   (clk),
    .we    (finish),
    .waddr (slot),
    .wdata (wr_entry),
    .re    (accept),
    .raddr (req.user_id[USER_W-1:0]),
    .rdata (rd_entry)
  );

  assign elapsed     = hit ? (now - rd_entry.stamp) : 32'd0;
  assign tokens_base = hit ? rd_entry.tokens : capacity;

  ptb_refill u_refill (
    .clk         (clk),
    .en_mul      (state == S_READ),
    .en_recip    (state == S_MUL),
    .elapsed     (elapsed),
    .tokens      (tokens_base),
    .rate_q8     (rate_q8),
    .capacity    (capacity),
    .allowed     (allowed),
    .tokens_left (tokens_left)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp <= '{allowed: allowed, tokens_left: tokens_left};
    end
  end

endmodule

### rtl/ptb_bucket_ram.sv
module ptb_bucket_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ptb_pkg::USER_W-1:0]  waddr,
  input  ptb_pkg::entry_t             wdata,
  input  logic                        re,
  input  logic [ptb_pkg::USER_W-1:0]  raddr,
  output ptb_pkg::entry_t             rdata
);
  import ptb_pkg::*;

  entry_t mem [USERS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ptb_refill.sv
module ptb_refill (
  input  logic        clk,
  input  logic        en_mul,
  input  logic        en_recip,
  input  logic [31:0] elapsed,
  input  logic [15:0] tokens,
  input  logic [15:0] rate_q8,
  input  logic [15:0] capacity,
  output logic        allowed,
  output logic [15:0] tokens_left
);
  import ptb_pkg::*;

  logic [47:0] prod;
  logic [15:0] tok1;
  logic [46:0] recip;
  logic        big;
  logic [15:0] tok2;

  logic [36:0] scaled;
  logic [15:0] quot;
  logic [16:0] sum;
  logic [15:0] level;

  assign scaled = prod[47:REFILL_SHIFT];

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod <= {16'd0, elapsed} * {32'd0, rate_q8};
      tok1 <= tokens;
    end
    if (en_recip) begin
      recip <= {24'd0, scaled[QUOT_X_W-1:0]} * {23'd0, RECIP_M};
      big   <= (scaled >= SAT_LIMIT);
      tok2  <= tok1;
    end
  end

  always_comb begin
    quot = recip[RECIP_SHIFT+15:RECIP_SHIFT];
    sum  = {1'b0, tok2} + {1'b0, quot};
    if (big || (sum > {1'b0, capacity})) begin
      level = capacity;
    end else begin
      level = sum[15:0];
    end
    allowed     = (level != 16'd0);
    tokens_left = level - {15'd0, allowed};
  end

endmodule
